// ===== src/serial_rgb_led_line_driver_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SERIAL_RGB_LED_LINE_DRIVER_DEFINES_SVH
`define SERIAL_RGB_LED_LINE_DRIVER_DEFINES_SVH

// Same-cycle implication, disabled while the given reset term is high.
`define SRLD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srld check failed");

// Next-cycle implication, disabled while the given reset term is high.
`define SRLD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srld check failed");

`endif

// ===== src/srld_pkg.sv =====
package srld_pkg;

   localparam int MAX_LEDS       = 16;
   localparam int LED_INDEX_W    = 4;
   localparam int LED_COUNT_W    = 5;
   localparam int COLOR_W        = 24;
   localparam int BIT_COUNT_W    = 5;
   localparam int BITS_PER_PIXEL = 24;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATCH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE     = 3'd4;

   localparam logic [7:0]             ZERO_HIGH_RESET  = 8'd18;
   localparam logic [7:0]             ONE_HIGH_RESET   = 8'd50;
   localparam logic [7:0]             BIT_PERIOD_RESET = 8'd90;
   localparam logic [15:0]            LATCH_RESET      = 16'd21600;
   localparam logic [LED_COUNT_W-1:0] ACTIVE_RESET     = 5'd10;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_WRITE_ONE = 2'd1,
      CMD_WRITE_ALL = 2'd2,
      CMD_START     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_SEND  = 3'b010,
      PH_LATCH = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0]             command;
      logic [LED_INDEX_W-1:0] pixel_index;
      logic [7:0]             red;
      logic [7:0]             green;
      logic [7:0]             blue;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic                   write_one;
      logic                   write_all;
      logic [LED_INDEX_W-1:0] index;
      logic [COLOR_W-1:0]     color;
   } store_wr_type;

endpackage

// ===== src/srld_pixel_store.sv =====
module srld_pixel_store (
   input  logic                               clock,
   input  logic                               reset,
   input  srld_pkg::store_wr_type             wr,
   input  logic [srld_pkg::LED_INDEX_W-1:0]   rd_addr,
   output logic [srld_pkg::COLOR_W-1:0]       rd_data
);

   logic [srld_pkg::COLOR_W-1:0] pixel_ff [srld_pkg::MAX_LEDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < srld_pkg::MAX_LEDS; i++) begin
            pixel_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < srld_pkg::MAX_LEDS; i++) begin
            if (wr.write_all ||
                (wr.write_one && (wr.index == srld_pkg::LED_INDEX_W'(i)))) begin
               pixel_ff[i] <= wr.color;
            end
         end
      end
   end

   assign rd_data = pixel_ff[rd_addr];

endmodule

// ===== src/serial_rgb_led_line_driver.sv =====
// Serial RGB LED line driver. Each request word carries one command: a tick
// advances the line waveform by one tick, the two write commands set one
// pixel or all sixteen pixels of the store (green, red, blue order on the
// line, most significant bit first), and a start command begins a frame.
// Writes and starts are ignored while a frame or its latch period runs.
// Every request word yields exactly one response word with the line level
// for that tick, the busy flag and the frame-done pulse. A word is processed
// combinationally between the request register and the response register, so
// one word per clock is sustained while the response side does not stall.
// The request side stalls while reset is high. The pixel store clears at
// reset with no sweep.
module serial_rgb_led_line_driver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  srld_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output srld_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [srld_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [srld_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic [7:0]                         zero_high_ff;
   logic [7:0]                         one_high_ff;
   logic [7:0]                         bit_period_ff;
   logic [15:0]                        latch_ticks_ff;
   logic [srld_pkg::LED_COUNT_W-1:0]   active_leds_ff;

   logic                               in_valid_ff, in_valid_in;
   srld_pkg::req_type                  in_word_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   srld_pkg::rsp_type                  rsp_word_ff, rsp_word_in;

   srld_pkg::phase_type                phase_ff, phase_in;
   logic [srld_pkg::LED_INDEX_W-1:0]   pixel_counter_ff, pixel_counter_in;
   logic [srld_pkg::BIT_COUNT_W-1:0]   bit_counter_ff, bit_counter_in;
   logic [7:0]                         slot_ticks_ff, slot_ticks_in;
   logic [15:0]                        latch_counter_ff, latch_counter_in;
   logic [srld_pkg::COLOR_W-1:0]       shift_word_ff, shift_word_in;

   logic                               accept;
   logic                               advance;
   logic [srld_pkg::LED_COUNT_W-1:0]   led_count;
   logic [srld_pkg::LED_COUNT_W-1:0]   next_pixel;
   logic [7:0]                         high_now;
   logic [7:0]                         high_next;
   logic [7:0]                         slot_inc;
   logic [15:0]                        latch_inc;
   logic [srld_pkg::BIT_COUNT_W-1:0]   bit_inc;
   logic                               level_now;
   srld_pkg::store_wr_type             store_wr;
   logic [srld_pkg::LED_INDEX_W-1:0]   rd_addr;
   logic [srld_pkg::COLOR_W-1:0]       rd_data;

   srld_pixel_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (store_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (in_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_word_ff;

   assign led_count = (active_leds_ff > srld_pkg::LED_COUNT_W'(srld_pkg::MAX_LEDS)) ?
                      srld_pkg::LED_COUNT_W'(srld_pkg::MAX_LEDS) : active_leds_ff;
   assign next_pixel = {1'b0, pixel_counter_ff} + srld_pkg::LED_COUNT_W'(1);
   assign high_now   = shift_word_ff[srld_pkg::COLOR_W-1] ? one_high_ff : zero_high_ff;
   assign high_next  = shift_word_in[srld_pkg::COLOR_W-1] ? one_high_ff : zero_high_ff;
   assign slot_inc   = slot_ticks_ff + 8'd1;
   assign latch_inc  = latch_counter_ff + 16'd1;
   assign bit_inc    = bit_counter_ff + srld_pkg::BIT_COUNT_W'(1);
   assign level_now  = (phase_ff == srld_pkg::PH_SEND) && (slot_ticks_ff < high_now);

   always_comb begin
      phase_in         = phase_ff;
      pixel_counter_in = pixel_counter_ff;
      bit_counter_in   = bit_counter_ff;
      slot_ticks_in    = slot_ticks_ff;
      latch_counter_in = latch_counter_ff;
      shift_word_in    = shift_word_ff;
      store_wr         = '0;
      store_wr.index   = in_word_ff.pixel_index;
      store_wr.color   = {in_word_ff.green, in_word_ff.red, in_word_ff.blue};
      rd_addr          = '0;
      rsp_word_in      = '0;

      if (advance) begin
         unique case (srld_pkg::cmd_type'(in_word_ff.command))
            srld_pkg::CMD_TICK: begin
               unique case (phase_ff)
                  srld_pkg::PH_SEND: begin
                     slot_ticks_in = slot_inc;
                     if ((slot_inc >= bit_period_ff) || (slot_inc == 8'd0)) begin
                        slot_ticks_in  = '0;
                        shift_word_in  = {shift_word_ff[srld_pkg::COLOR_W-2:0], 1'b0};
                        bit_counter_in = bit_inc;
                        if (bit_inc >= srld_pkg::BIT_COUNT_W'(srld_pkg::BITS_PER_PIXEL)) begin
                           if (next_pixel >= led_count) begin
                              phase_in         = srld_pkg::PH_LATCH;
                              latch_counter_in = '0;
                           end else begin
                              pixel_counter_in = next_pixel[srld_pkg::LED_INDEX_W-1:0];
                              rd_addr          = next_pixel[srld_pkg::LED_INDEX_W-1:0];
                              shift_word_in    = rd_data;
                              bit_counter_in   = '0;
                           end
                        end
                     end
                  end
                  srld_pkg::PH_LATCH: begin
                     latch_counter_in = latch_inc;
                     if ((latch_inc >= latch_ticks_ff) || (latch_inc == 16'd0)) begin
                        latch_counter_in       = '0;
                        phase_in               = srld_pkg::PH_IDLE;
                        rsp_word_in.frame_done = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            srld_pkg::CMD_WRITE_ONE: begin
               store_wr.write_one = (phase_ff == srld_pkg::PH_IDLE) &&
                                    ({1'b0, in_word_ff.pixel_index} < led_count);
            end
            srld_pkg::CMD_WRITE_ALL: begin
               store_wr.write_all = (phase_ff == srld_pkg::PH_IDLE);
            end
            srld_pkg::CMD_START: begin
               if (phase_ff == srld_pkg::PH_IDLE) begin
                  pixel_counter_in = '0;
                  bit_counter_in   = '0;
                  slot_ticks_in    = '0;
                  if (led_count == '0) begin
                     shift_word_in    = '0;
                     phase_in         = srld_pkg::PH_LATCH;
                     latch_counter_in = '0;
                  end else begin
                     shift_word_in = rd_data;
                     phase_in      = srld_pkg::PH_SEND;
                  end
               end
            end
            default: begin
            end
         endcase

         if (in_word_ff.command == srld_pkg::CMD_TICK) begin
            rsp_word_in.line_level = level_now;
         end else begin
            rsp_word_in.line_level = (phase_in == srld_pkg::PH_SEND) &&
                                     (slot_ticks_in < high_next);
         end
         rsp_word_in.busy_res = (phase_in != srld_pkg::PH_IDLE);
      end
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         phase_ff         <= srld_pkg::PH_IDLE;
         pixel_counter_ff <= '0;
         bit_counter_ff   <= '0;
         slot_ticks_ff    <= '0;
         latch_counter_ff <= '0;
         shift_word_ff    <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         phase_ff         <= phase_in;
         pixel_counter_ff <= pixel_counter_in;
         bit_counter_ff   <= bit_counter_in;
         slot_ticks_ff    <= slot_ticks_in;
         latch_counter_ff <= latch_counter_in;
         shift_word_ff    <= shift_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_payload;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff   <= srld_pkg::ZERO_HIGH_RESET;
         one_high_ff    <= srld_pkg::ONE_HIGH_RESET;
         bit_period_ff  <= srld_pkg::BIT_PERIOD_RESET;
         latch_ticks_ff <= srld_pkg::LATCH_RESET;
         active_leds_ff <= srld_pkg::ACTIVE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            srld_pkg::CSR_ZERO_HIGH:  zero_high_ff   <= csr_write_data[7:0];
            srld_pkg::CSR_ONE_HIGH:   one_high_ff    <= csr_write_data[7:0];
            srld_pkg::CSR_BIT_PERIOD: bit_period_ff  <= csr_write_data[7:0];
            srld_pkg::CSR_LATCH:      latch_ticks_ff <= csr_write_data[15:0];
            srld_pkg::CSR_ACTIVE:     active_leds_ff <= csr_write_data[srld_pkg::LED_COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== src/srld_checker.sv =====
`include "serial_rgb_led_line_driver_defines.svh"

module srld_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input srld_pkg::rsp_type                 rsp_payload
);

   `SRLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `SRLD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `SRLD_ASSERT_NOW(a_reset_stall, clock, 1'b0, reset, req_stall)
   `SRLD_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_payload.frame_done, !rsp_payload.busy_res)
   `SRLD_ASSERT_NOW(a_high_busy, clock, reset, rsp_valid && rsp_payload.line_level, rsp_payload.busy_res)

endmodule

bind serial_rgb_led_line_driver srld_checker u_srld_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int REPORT_LINES = 40;
   localparam int RANDOM_WORDS = 450;

   typedef struct packed {
      srld_pkg::req_type word;
      logic              known;
      srld_pkg::rsp_type result;
   } script_row_type;

   localparam int SCRIPT_ROWS = 13;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      {srld_pkg::CMD_TICK,      4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 3'b000},
      {srld_pkg::CMD_WRITE_ALL, 4'd0,  8'hFF, 8'h00, 8'h00, 1'b1, 3'b000},
      {srld_pkg::CMD_WRITE_ONE, 4'd0,  8'h00, 8'hFF, 8'hFF, 1'b1, 3'b000},
      {srld_pkg::CMD_WRITE_ONE, 4'd9,  8'h00, 8'h00, 8'h01, 1'b1, 3'b000},
      {srld_pkg::CMD_WRITE_ONE, 4'd10, 8'h55, 8'hAA, 8'h55, 1'b1, 3'b000},
      {srld_pkg::CMD_WRITE_ONE, 4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b000},
      {srld_pkg::CMD_TICK,      4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b000},
      {srld_pkg::CMD_START,     4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
      {srld_pkg::CMD_WRITE_ALL, 4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
      {srld_pkg::CMD_START,     4'd15, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b110},
      {srld_pkg::CMD_WRITE_ONE, 4'd1,  8'h12, 8'h34, 8'h56, 1'b1, 3'b110},
      {srld_pkg::CMD_TICK,      4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
      {srld_pkg::CMD_TICK,      4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 3'b000}
   };

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   srld_pkg::req_type                req_payload      = '0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   srld_pkg::rsp_type                rsp_payload;
   logic                             csr_write_enable = 1'b0;
   logic [srld_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [srld_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;

   logic [srld_pkg::COLOR_W-1:0]     pixel_colors [srld_pkg::MAX_LEDS];
   srld_pkg::phase_type              line_phase   = srld_pkg::PH_IDLE;
   logic [srld_pkg::LED_INDEX_W-1:0] pixel_count  = '0;
   logic [srld_pkg::BIT_COUNT_W-1:0] bit_count    = '0;
   logic [7:0]                       slot_count   = '0;
   logic [15:0]                      latch_count  = '0;
   logic [srld_pkg::COLOR_W-1:0]     shift_reg    = '0;

   logic [7:0]                       zero_high    = srld_pkg::ZERO_HIGH_RESET;
   logic [7:0]                       one_high     = srld_pkg::ONE_HIGH_RESET;
   logic [7:0]                       slot_len     = srld_pkg::BIT_PERIOD_RESET;
   logic [15:0]                      latch_len    = srld_pkg::LATCH_RESET;
   logic [srld_pkg::LED_COUNT_W-1:0] active_count = srld_pkg::ACTIVE_RESET;

   srld_pkg::rsp_type pending_line_words [$];
   int      live_words = 0;
   int      failures   = 0;
   int      cycles     = 0;
   int      gap_pct    = 20;
   int      stall_pct  = 45;

   serial_rgb_led_line_driver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic int leds_sent();
      return (active_count > 5'(srld_pkg::MAX_LEDS)) ?
             srld_pkg::MAX_LEDS : int'(active_count);
   endfunction

   function automatic logic line_high();
      if (line_phase != srld_pkg::PH_SEND) begin
         return 1'b0;
      end
      return slot_count < (shift_reg[srld_pkg::COLOR_W-1] ? one_high : zero_high);
   endfunction

   function automatic void load_pixel(input int idx);
      shift_reg  = pixel_colors[idx];
      bit_count  = '0;
      slot_count = '0;
   endfunction

   function automatic srld_pkg::rsp_type advance_line(input srld_pkg::req_type w);
      srld_pkg::rsp_type r;
      logic [23:0]       colour;
      logic              was_busy;
      r        = '0;
      colour   = {w.green, w.red, w.blue};
      was_busy = (line_phase != srld_pkg::PH_IDLE);
      if (w.command == srld_pkg::CMD_TICK) begin
         if (was_busy) begin
            live_words++;
         end
         if (line_phase == srld_pkg::PH_SEND) begin
            r.line_level = line_high();
            slot_count   = slot_count + 8'd1;
            if (slot_count >= slot_len || slot_count == 8'd0) begin
               slot_count = '0;
               shift_reg  = shift_reg << 1;
               bit_count  = bit_count + 5'd1;
               if (int'(bit_count) >= srld_pkg::BITS_PER_PIXEL) begin
                  if (int'(pixel_count) + 1 >= leds_sent()) begin
                     line_phase  = srld_pkg::PH_LATCH;
                     latch_count = '0;
                  end else begin
                     pixel_count = pixel_count + 4'd1;
                     load_pixel(int'(pixel_count));
                  end
               end
            end
         end else if (line_phase == srld_pkg::PH_LATCH) begin
            latch_count = latch_count + 16'd1;
            if (latch_count >= latch_len || latch_count == 16'd0) begin
               latch_count  = '0;
               line_phase   = srld_pkg::PH_IDLE;
               r.frame_done = 1'b1;
            end
         end
      end else begin
         if (!was_busy) begin
            unique case (w.command)
               srld_pkg::CMD_WRITE_ONE: begin
                  if (int'(w.pixel_index) < leds_sent()) begin
                     pixel_colors[w.pixel_index] = colour;
                     live_words++;
                  end
               end
               srld_pkg::CMD_WRITE_ALL: begin
                  foreach (pixel_colors[i]) pixel_colors[i] = colour;
                  live_words++;
               end
               default: begin
                  live_words++;
                  pixel_count = '0;
                  if (leds_sent() == 0) begin
                     shift_reg   = '0;
                     bit_count   = '0;
                     slot_count  = '0;
                     line_phase  = srld_pkg::PH_LATCH;
                     latch_count = '0;
                  end else begin
                     line_phase = srld_pkg::PH_SEND;
                     load_pixel(0);
                  end
               end
            endcase
         end
         r.line_level = line_high();
      end
      r.busy_res = (line_phase != srld_pkg::PH_IDLE);
      return r;
   endfunction

   function automatic srld_pkg::req_type make_word(input srld_pkg::cmd_type c,
                                                   input int idx);
      srld_pkg::req_type w;
      w.command     = c;
      w.pixel_index = 4'(idx);
      w.red         = 8'($urandom);
      w.green       = 8'($urandom);
      w.blue        = 8'($urandom);
      return w;
   endfunction

   task automatic flag_mismatch(input string msg);
      failures++;
      if (failures <= REPORT_LINES) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic send_word(input srld_pkg::req_type w, input logic known = 1'b0,
                            input srld_pkg::rsp_type result = '0);
      srld_pkg::rsp_type predicted;
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall);
      predicted = advance_line(w);
      pending_line_words.push_back(known ? result : predicted);
   endtask

   task automatic finish_frame(input int noise_pct);
      while (line_phase != srld_pkg::PH_IDLE) begin
         if ($urandom_range(99) < noise_pct) begin
            send_word(make_word(srld_pkg::cmd_type'(2'($urandom_range(1, 3))),
                                $urandom_range(15)));
         end else begin
            send_word(make_word(srld_pkg::CMD_TICK, $urandom_range(15)));
         end
      end
   endtask

   task automatic run_frame(input int writes, input int noise_pct);
      repeat (writes) begin
         if ($urandom_range(3) == 0) begin
            send_word(make_word(srld_pkg::CMD_WRITE_ALL, $urandom_range(15)));
         end else if ($urandom_range(9) < 7 && leds_sent() > 0) begin
            send_word(make_word(srld_pkg::CMD_WRITE_ONE, $urandom_range(leds_sent() - 1)));
         end else begin
            send_word(make_word(srld_pkg::CMD_WRITE_ONE, $urandom_range(15)));
         end
      end
      repeat ($urandom_range(2)) send_word(make_word(srld_pkg::CMD_TICK, $urandom_range(15)));
      send_word(make_word(srld_pkg::CMD_START, $urandom_range(15)));
      finish_frame(noise_pct);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_line_words.size() != 0) @(posedge clock);
   endtask

   task automatic program_timing(input logic [7:0] zh, input logic [7:0] oh,
                                 input logic [7:0] per, input logic [15:0] lat,
                                 input logic [4:0] act);
      logic [srld_pkg::CSR_INDEX_W-1:0] regs [5];
      logic [srld_pkg::CSR_DATA_W-1:0]  vals [5];
      regs = '{srld_pkg::CSR_ZERO_HIGH, srld_pkg::CSR_ONE_HIGH, srld_pkg::CSR_BIT_PERIOD,
               srld_pkg::CSR_LATCH, srld_pkg::CSR_ACTIVE};
      vals = '{{8'h00, zh}, {8'h00, oh}, {8'h00, per}, lat, {11'h000, act}};
      csr_write_enable <= 1'b1;
      for (int k = 0; k < 5; k++) begin
         csr_index      <= regs[k];
         csr_write_data <= vals[k];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      zero_high    = zh;
      one_high     = oh;
      slot_len     = per;
      latch_len    = lat;
      active_count = act;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : response_check
      srld_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_line_words.size() == 0) begin
            flag_mismatch("response word with nothing pending");
         end else begin
            want = pending_line_words.pop_front();
            if (rsp_payload.line_level !== want.line_level) begin
               flag_mismatch($sformatf("line_level %b, wanted %b",
                                       rsp_payload.line_level, want.line_level));
            end
            if (rsp_payload.busy_res !== want.busy_res) begin
               flag_mismatch($sformatf("busy_res %b, wanted %b",
                                       rsp_payload.busy_res, want.busy_res));
            end
            if (rsp_payload.frame_done !== want.frame_done) begin
               flag_mismatch($sformatf("frame_done %b, wanted %b",
                                       rsp_payload.frame_done, want.frame_done));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int base;
      int phase_start;
      int budget;
      int per;
      int corner_cfg [4][5] = '{
         '{1,   255, 4, 1, 1},
         '{255, 1,   0, 0, 0},
         '{200, 3,   0, 0, 31},
         '{1,   1,   1, 2, 2}
      };
      foreach (pixel_colors[i]) pixel_colors[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The opening rows run at the reset timing; the frame they start ends at a short timing.
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         send_word(SCRIPT[r].word, SCRIPT[r].known, SCRIPT[r].result);
      end
      wait_drained();
      program_timing(8'd1, 8'd2, 8'd2, 16'd4, 5'd1);
      finish_frame(5);

      for (int k = 0; k < 4; k++) begin
         wait_drained();
         program_timing(8'(corner_cfg[k][0]), 8'(corner_cfg[k][1]), 8'(corner_cfg[k][2]),
                        16'(corner_cfg[k][3]), 5'(corner_cfg[k][4]));
         run_frame(2, 10);
      end

      for (int p = 0; p < 3; p++) begin
         gap_pct   = (p == 0) ? 20 : ((p == 1) ? 45 : 0);
         stall_pct = (p == 0) ? 45 : ((p == 1) ? 20 : 0);
         base = live_words;
         while (live_words - base < RANDOM_WORDS / 3) begin
            wait_drained();
            per = $urandom_range(3);
            program_timing(8'($urandom_range(1, per + 2)), 8'($urandom_range(1, per + 2)),
                           8'(per), 16'($urandom_range(1, 12)),
                           ($urandom_range(7) == 0) ? 5'd16 : 5'($urandom_range(1, 3)));
            phase_start = live_words;
            budget      = $urandom_range(40, 100);
            while (live_words - phase_start < budget) begin
               if ($urandom_range(9) == 0) begin
                  send_word(make_word(srld_pkg::cmd_type'(2'($urandom_range(3))),
                                      $urandom_range(15)));
               end else begin
                  run_frame($urandom_range(4), 12);
               end
            end
            finish_frame(0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== serial_rgb_led_line_driver.f =====
+incdir+src
src/srld_pkg.sv
src/srld_pixel_store.sv
src/serial_rgb_led_line_driver.sv
src/srld_checker.sv
dv/testbench.sv
